// ===== rtl/tbc_pkg.sv =====
// Package for the time base counter: request and register select codes,
// the state and result record types shared by the step logic and the top level.
// No dependencies.
package tbc_pkg;

    localparam int PRE_W = 7;
    localparam int CNT_W = 8;
    localparam int ADJ_W = 11;
    localparam int IRQ_W = 4;

    localparam logic [1:0] REQ_STEP  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] SEL_COUNT   = 2'd0;
    localparam logic [1:0] SEL_ADJ_LO  = 2'd1;
    localparam logic [1:0] SEL_ADJ_HI  = 2'd2;
    localparam logic [1:0] SEL_NONE    = 2'd3;

    localparam logic [PRE_W-1:0] PRE_TOP = 7'h40;

    typedef struct packed {
        logic [PRE_W-1:0] prescaler;
        logic [CNT_W-1:0] base_count;
        logic             reset_armed;
        logic             skip_next_tick;
        logic             force_tick;
        logic [ADJ_W-1:0] adjust_value;
        logic [CNT_W-1:0] last_tap_mask;
    } t_state;

    typedef struct packed {
        logic [7:0]       read_data;
        logic [IRQ_W-1:0] irq_raise;
        logic [CNT_W-1:0] tap_mask;
        logic [PRE_W-1:0] prescale_mask;
    } t_result;

endpackage

// ===== rtl/tbc_step.sv =====
// Combinational step logic of the time base counter: next state and result
// for one transaction. Depends on tbc_pkg.
module tbc_step (
    input  tbc_pkg::t_state  i_state,
    input  logic [1:0]       i_req_type,
    input  logic             i_low_tick,
    input  logic [1:0]       i_reg_sel,
    input  logic [7:0]       i_write_data,
    output tbc_pkg::t_state  o_state,
    output tbc_pkg::t_result o_result
);
    import tbc_pkg::*;

    logic [PRE_W-1:0] pre_next;
    logic [PRE_W-1:0] pmask;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cmask;

    assign pre_next = i_state.prescaler + PRE_W'(1);
    assign pmask    = i_state.prescaler & ~pre_next;
    assign cnt_next = i_state.base_count + CNT_W'(1);
    assign cmask    = i_state.base_count & ~cnt_next;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_req_type)
            REQ_STEP: begin
                if (i_state.reset_armed) begin
                    o_result.irq_raise     = '1;
                    o_state.last_tap_mask  = '1;
                    o_state.skip_next_tick = 1'b1;
                    o_state.reset_armed    = 1'b0;
                end
                if (i_low_tick || i_state.force_tick) begin
                    o_state.force_tick     = 1'b0;
                    o_state.prescaler      = pre_next;
                    o_result.prescale_mask = pmask;
                    if (o_state.skip_next_tick) begin
                        o_state.skip_next_tick = 1'b0;
                    end else begin
                        o_state.last_tap_mask = '0;
                        if ((pmask & PRE_TOP) != '0) begin
                            o_state.base_count    = cnt_next;
                            o_state.last_tap_mask = cmask;
                            o_result.irq_raise = o_result.irq_raise
                                | {cmask[6], cmask[4], cmask[2], cmask[0]};
                        end
                    end
                end
                o_result.tap_mask = o_state.last_tap_mask;
            end
            REQ_READ: begin
                case (i_reg_sel)
                    SEL_COUNT:  o_result.read_data = i_state.base_count;
                    SEL_ADJ_LO: o_result.read_data = i_state.adjust_value[7:0];
                    SEL_ADJ_HI: o_result.read_data =
                        {5'd0, i_state.adjust_value[ADJ_W-1:8]};
                    default:    o_result.read_data = '0;
                endcase
            end
            REQ_WRITE: begin
                case (i_reg_sel)
                    SEL_COUNT: begin
                        o_state.base_count  = '0;
                        o_state.reset_armed = 1'b1;
                        o_state.force_tick  = 1'b1;
                    end
                    SEL_ADJ_LO: o_state.adjust_value[7:0] = i_write_data;
                    SEL_ADJ_HI: o_state.adjust_value[ADJ_W-1:8] = i_write_data[2:0];
                    default: o_state = i_state;
                endcase
            end
            default: o_state = i_state;
        endcase
    end

endmodule

// ===== rtl/time_base_counter_core.sv =====
// Time base counter core: state registers, output register with skid stage.
// Depends on tbc_pkg and tbc_step.
// An accepted transaction's result is registered in the output register,
// or in the skid stage while the output waits. Throughput: one transaction
// per cycle while o_ready is high; o_ready is low while the skid is full.
// Reset: synchronous, active low; clears all counter state and both valids.
module time_base_counter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  logic                         i_low_tick,
    input  logic [1:0]                   i_reg_sel,
    input  logic [7:0]                   i_write_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_read_data,
    output logic [tbc_pkg::IRQ_W-1:0]    o_irq_raise,
    output logic [tbc_pkg::CNT_W-1:0]    o_tap_mask,
    output logic [tbc_pkg::PRE_W-1:0]    o_prescale_mask
);
    import tbc_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    accept;
    logic    take;

    tbc_step u_step (
        .i_state      (r_state),
        .i_req_type   (i_req_type),
        .i_low_tick   (i_low_tick),
        .i_reg_sel    (i_reg_sel),
        .i_write_data (i_write_data),
        .o_state      (n_state),
        .o_result     (step_result)
    );

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign take    = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !take) begin
                r_skid <= step_result;
            end else begin
                r_out <= step_result;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_out.read_data;
    assign o_irq_raise     = r_out.irq_raise;
    assign o_tap_mask      = r_out.tap_mask;
    assign o_prescale_mask = r_out.prescale_mask;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid stage holds a result while the output register is empty.");

    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_data != '0) |->
        (o_irq_raise == '0 && o_tap_mask == '0 && o_prescale_mask == '0))
        else $error("A read result carries step outputs.");

    a_count_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_WRITE && i_reg_sel == SEL_COUNT) |=>
        (r_state.reset_armed && r_state.force_tick && r_state.base_count == '0))
        else $error("Counter write did not clear the counter and arm the reset.");

    a_reset_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_STEP && r_state.reset_armed) |=>
        !r_state.reset_armed)
        else $error("Armed reset was not cleared by a clock step.");

endmodule
